@@ sv/assert_macros.svh @@
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms. They compile to nothing when
// NO_ASSERTIONS is defined.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS
// Same-cycle implication, checked outside reset.
`define ASSERT_IMPLY(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
// Next-cycle implication, checked outside reset.
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define ASSERT_IMPLY(lbl, clk, rst_n, ante, cons)
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif

`endif

@@ sv/rfq_pkg.sv @@
// ----------------------------------------------------------------------------
// rfq_pkg
// Widths, constants, command and status bundles and helpers shared by the
// fit quality block.
// ----------------------------------------------------------------------------
package rfq_pkg;

    localparam int VALUE_WIDTH = 24;
    localparam int MAX_CASES   = 64;
    localparam int MAX_TARGETS = 16;

    localparam int CASE_W = 7;
    localparam int TGT_W  = 5;
    localparam int COEF_W = 7;
    localparam int IDX_W  = 4;
    localparam int OUT_W  = 32;
    localparam int STAT_W = 2;

    localparam int ROW_W = $clog2(MAX_CASES);
    localparam int COL_W = $clog2(MAX_TARGETS);

    localparam int FRAC_BITS = 24;
    localparam int SUM_W   = VALUE_WIDTH + ROW_W;
    localparam int ESQ_W   = 2 * VALUE_WIDTH;
    localparam int YSQ_W   = 2 * VALUE_WIDTH - 1;
    localparam int SSE_W   = ESQ_W + ROW_W;
    localparam int SY2_W   = YSQ_W + ROW_W;
    localparam int DD_W    = SY2_W + ROW_W + 1;
    localparam int A_W     = SSE_W + ROW_W + 1;
    localparam int DIVN_W  = A_W + FRAC_BITS;
    localparam int DIVD_W  = DD_W;
    localparam int RATIO_W = 2 * FRAC_BITS + 1;
    localparam int PROD_W  = RATIO_W + ROW_W;
    localparam int DIFF_W  = COEF_W + 2;
    localparam int WIDE_W  = 64;

    localparam logic [STAT_W-1:0] STATUS_OK         = 2'd0;
    localparam logic [STAT_W-1:0] STATUS_ZERO_SPAN  = 2'd1;
    localparam logic [STAT_W-1:0] STATUS_CASES_COEF = 2'd2;

    localparam logic signed [WIDE_W-1:0] ONE_Q = WIDE_W'(64'sd1 <<< FRAC_BITS);
    localparam logic [RATIO_W-1:0] RATIO_CAP = RATIO_W'(1) << (RATIO_W - 1);

    typedef struct packed {
        logic accept;
        logic first_target;
        logic prep;
        logic spread;
        logic div_start;
        logic div_sel_adj;
        logic zero_take;
        logic ratio_take;
        logic scale;
        logic adj_take;
        logic emit;
    } cmd_t;

    typedef struct packed {
        logic last_item;
        logic spread_zero;
        logic diff_zero;
        logic div_done;
        logic last_target;
    } stat_t;

    function automatic logic [OUT_W-1:0] sat_out(input logic signed [WIDE_W-1:0] v);
        logic signed [WIDE_W-1:0] hi;
        logic signed [WIDE_W-1:0] lo;
        hi = WIDE_W'(64'sd2147483647);
        lo = -WIDE_W'(64'sd2147483648);
        if (v > hi) begin
            return OUT_W'(hi);
        end
        if (v < lo) begin
            return OUT_W'(lo);
        end
        return v[OUT_W-1:0];
    endfunction

endpackage

@@ sv/rfq_divider.sv @@
// ----------------------------------------------------------------------------
// rfq_divider
// Restoring shift-subtract divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module rfq_divider
    import rfq_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  logic [DIVN_W-1:0] dividend,
    input  logic [DIVD_W-1:0] divisor,
    output logic              done,
    output logic [DIVN_W-1:0] quotient
);

    localparam int CNT_W = $clog2(DIVN_W + 1);

    logic              run_reg, run_next;
    logic              done_reg, done_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic [DIVN_W-1:0] quo_reg, quo_next;
    logic [DIVD_W-1:0] rem_reg, rem_next;
    logic [DIVD_W-1:0] div_reg, div_next;
    logic [DIVD_W:0]   rem_shift;
    logic [DIVD_W:0]   rem_sub;
    logic              ge;

    assign rem_shift = {rem_reg, quo_reg[DIVN_W-1]};
    assign rem_sub   = rem_shift - {1'b0, div_reg};
    assign ge        = (rem_shift >= {1'b0, div_reg});

    always_comb
    begin
        run_next  = run_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        div_next  = div_reg;
        if (start)
        begin
            run_next = 1'b1;
            cnt_next = '0;
            quo_next = dividend;
            rem_next = '0;
            div_next = divisor;
        end
        else if (run_reg)
        begin
            quo_next = {quo_reg[DIVN_W-2:0], ge};
            rem_next = ge ? rem_sub[DIVD_W-1:0] : rem_shift[DIVD_W-1:0];
            cnt_next = cnt_reg + CNT_W'(1);
            if (cnt_reg == CNT_W'(DIVN_W - 1))
            begin
                run_next  = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            run_reg  <= run_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        div_reg <= div_next;
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

@@ sv/rfq_datapath.sv @@
// ----------------------------------------------------------------------------
// rfq_datapath
// Load counters, per-target sums and the arithmetic that turns them into
// R2 and adjusted R2.
// ----------------------------------------------------------------------------
module rfq_datapath
    import rfq_pkg::*;
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  cmd_t                    cmd,
    output stat_t                   stat,
    input  logic                    clear,
    input  logic [CASE_W-1:0]       n_eff,
    input  logic [TGT_W-1:0]        t_eff,
    input  logic signed [VALUE_WIDTH-1:0] measured_value,
    input  logic signed [VALUE_WIDTH-1:0] predicted_value,
    input  logic [COEF_W-1:0]       coef_count,
    output logic                    result_valid,
    output logic [IDX_W-1:0]        target_index,
    output logic signed [OUT_W-1:0] r_squared,
    output logic signed [OUT_W-1:0] r_squared_adjusted,
    output logic [STAT_W-1:0]       status,
    output logic                    last_result
);

    // Load position.
    logic [ROW_W-1:0] row_reg, row_next;
    logic [COL_W-1:0] col_reg, col_next;
    logic [ROW_W-1:0] n_last;
    logic [COL_W-1:0] t_last;

    // Capture stage of an accepted beat.
    logic                          s1_valid_reg;
    logic signed [VALUE_WIDTH-1:0] s1_m_reg;
    logic signed [VALUE_WIDTH-1:0] s1_p_reg;
    logic [COEF_W-1:0]             s1_coef_reg;
    logic [COL_W-1:0]              s1_col_reg;
    logic                          s1_row0_reg;

    // Per-target sums.
    logic signed [SUM_W-1:0] sum_mem  [MAX_TARGETS];
    logic [SSE_W-1:0]        sse_mem  [MAX_TARGETS];
    logic [SY2_W-1:0]        sy2_mem  [MAX_TARGETS];
    logic [COEF_W-1:0]       coef_mem [MAX_TARGETS];

    logic [COL_W-1:0] tgt_reg;
    logic [COL_W-1:0] idx;

    logic signed [VALUE_WIDTH:0] err;
    logic [VALUE_WIDTH-1:0]      err_abs;
    logic [VALUE_WIDTH-1:0]      m_abs;
    logic [ESQ_W-1:0]            esq;
    logic [YSQ_W-1:0]            ysq;

    // Result arithmetic.
    logic signed [SUM_W-1:0] sum_rd;
    logic [SUM_W-1:0]        sum_abs;
    logic [DD_W-1:0]         nsy2_reg;
    logic [DD_W-1:0]         s2_reg;
    logic [A_W-1:0]          a_reg;
    logic signed [DIFF_W-1:0] diff_reg;
    logic [DD_W-1:0]         dd_reg;
    logic [RATIO_W-1:0]      r_reg;
    logic [PROD_W-1:0]       prod_reg;
    logic [DIFF_W-1:0]       diff_abs;

    logic [DIVN_W-1:0] div_dividend;
    logic [DIVD_W-1:0] div_divisor;
    logic              div_done;
    logic [DIVN_W-1:0] div_quo;
    logic              ratio_cap;
    logic [RATIO_W-1:0] ratio_val;
    logic signed [PROD_W:0] t_signed;

    logic [OUT_W-1:0]  r2_res_reg;
    logic [OUT_W-1:0]  adj_res_reg;
    logic [STAT_W-1:0] stat_res_reg;

    logic                    valid_reg;
    logic [IDX_W-1:0]        idx_out_reg;
    logic signed [OUT_W-1:0] r2_out_reg;
    logic signed [OUT_W-1:0] adj_out_reg;
    logic [STAT_W-1:0]       stat_out_reg;
    logic                    last_out_reg;

    assign n_last = ROW_W'(n_eff - CASE_W'(1));
    assign t_last = COL_W'(t_eff - TGT_W'(1));

    assign stat.last_item   = (row_reg == n_last) && (col_reg == t_last);
    assign stat.spread_zero = (dd_reg == '0);
    assign stat.diff_zero   = (diff_reg == '0);
    assign stat.div_done    = div_done;
    assign stat.last_target = (tgt_reg == t_last);

    always_comb
    begin
        row_next = row_reg;
        col_next = col_reg;
        if (clear)
        begin
            row_next = '0;
            col_next = '0;
        end
        else if (cmd.accept)
        begin
            if (stat.last_item)
            begin
                row_next = '0;
                col_next = '0;
            end
            else if (col_reg == t_last)
            begin
                col_next = '0;
                row_next = row_reg + ROW_W'(1);
            end
            else
            begin
                col_next = col_reg + COL_W'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_reg      <= '0;
            col_reg      <= '0;
            s1_valid_reg <= 1'b0;
            valid_reg    <= 1'b0;
            tgt_reg      <= '0;
        end
        else
        begin
            row_reg      <= row_next;
            col_reg      <= col_next;
            s1_valid_reg <= cmd.accept;
            valid_reg    <= cmd.emit;
            if (cmd.first_target)
            begin
                tgt_reg <= '0;
            end
            else if (cmd.emit && !stat.last_target)
            begin
                tgt_reg <= tgt_reg + COL_W'(1);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            s1_m_reg    <= measured_value;
            s1_p_reg    <= predicted_value;
            s1_coef_reg <= coef_count;
            s1_col_reg  <= col_reg;
            s1_row0_reg <= (row_reg == '0);
        end
    end

    // The accumulate stage and the result sequence never overlap in time,
    // so one index serves both.
    assign idx = s1_valid_reg ? s1_col_reg : tgt_reg;

    assign err     = (VALUE_WIDTH+1)'(s1_m_reg) - (VALUE_WIDTH+1)'(s1_p_reg);
    assign err_abs = err[VALUE_WIDTH] ? VALUE_WIDTH'(-err) : VALUE_WIDTH'(err);
    assign m_abs   = s1_m_reg[VALUE_WIDTH-1] ? VALUE_WIDTH'(-s1_m_reg)
                                             : VALUE_WIDTH'(s1_m_reg);
    assign esq     = ESQ_W'(err_abs) * ESQ_W'(err_abs);
    assign ysq     = YSQ_W'(YSQ_W'(m_abs) * YSQ_W'(m_abs));

    // Row zero overwrites, so a new data set needs no clearing pass.
    always_ff @(posedge clk)
    begin
        if (s1_valid_reg)
        begin
            if (s1_row0_reg)
            begin
                sum_mem[idx]  <= SUM_W'(s1_m_reg);
                sse_mem[idx]  <= SSE_W'(esq);
                sy2_mem[idx]  <= SY2_W'(ysq);
                coef_mem[idx] <= s1_coef_reg;
            end
            else
            begin
                sum_mem[idx] <= sum_mem[idx] + SUM_W'(s1_m_reg);
                sse_mem[idx] <= sse_mem[idx] + SSE_W'(esq);
                sy2_mem[idx] <= sy2_mem[idx] + SY2_W'(ysq);
            end
        end
    end

    assign sum_rd  = sum_mem[idx];
    assign sum_abs = sum_rd[SUM_W-1] ? SUM_W'(-sum_rd) : SUM_W'(sum_rd);
    assign diff_abs = diff_reg[DIFF_W-1] ? DIFF_W'(-diff_reg) : DIFF_W'(diff_reg);

    assign div_dividend = cmd.div_sel_adj ? DIVN_W'(prod_reg)
                                          : {a_reg, {FRAC_BITS{1'b0}}};
    assign div_divisor  = cmd.div_sel_adj ? DIVD_W'(diff_abs) : dd_reg;

    rfq_divider u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (cmd.div_start),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .done     (div_done),
        .quotient (div_quo)
    );

    // A ratio of 2^48 or more is clamped; R2 saturates anyway, as does adjusted R2 when it is computed.
    assign ratio_cap = |div_quo[DIVN_W-1:RATIO_W-1];
    assign ratio_val = ratio_cap ? RATIO_CAP : div_quo[RATIO_W-1:0];
    assign t_signed  = diff_reg[DIFF_W-1] ? -(PROD_W+1)'(div_quo[PROD_W-1:0])
                                          : (PROD_W+1)'(div_quo[PROD_W-1:0]);

    always_ff @(posedge clk)
    begin
        if (cmd.prep)
        begin
            nsy2_reg <= DD_W'(n_eff) * DD_W'(sy2_mem[idx]);
            s2_reg   <= DD_W'(sum_abs) * DD_W'(sum_abs);
            a_reg    <= A_W'(n_eff) * A_W'(sse_mem[idx]);
            diff_reg <= DIFF_W'(n_eff) - DIFF_W'(coef_mem[idx]);
        end
        if (cmd.spread)
        begin
            dd_reg <= nsy2_reg - s2_reg;
        end
        if (cmd.zero_take)
        begin
            r2_res_reg   <= '0;
            adj_res_reg  <= '0;
            stat_res_reg <= STATUS_ZERO_SPAN;
        end
        if (cmd.ratio_take)
        begin
            r_reg        <= ratio_val;
            r2_res_reg   <= sat_out(ONE_Q - WIDE_W'(ratio_val));
            adj_res_reg  <= '0;
            stat_res_reg <= stat.diff_zero ? STATUS_CASES_COEF : STATUS_OK;
        end
        if (cmd.scale)
        begin
            prod_reg <= PROD_W'(r_reg) * PROD_W'(n_eff - CASE_W'(1));
        end
        if (cmd.adj_take)
        begin
            adj_res_reg <= sat_out(ONE_Q - WIDE_W'(t_signed));
        end
        if (cmd.emit)
        begin
            idx_out_reg  <= IDX_W'(tgt_reg);
            r2_out_reg   <= r2_res_reg;
            adj_out_reg  <= adj_res_reg;
            stat_out_reg <= stat_res_reg;
            last_out_reg <= stat.last_target;
        end
    end

    assign result_valid       = valid_reg;
    assign target_index       = idx_out_reg;
    assign r_squared          = r2_out_reg;
    assign r_squared_adjusted = adj_out_reg;
    assign status             = stat_out_reg;
    assign last_result        = last_out_reg;

endmodule

@@ sv/rfq_ctrl.sv @@
// ----------------------------------------------------------------------------
// rfq_ctrl
// Sequencer for loading a data set and producing one result per target.
// ----------------------------------------------------------------------------
module rfq_ctrl
    import rfq_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  start,
    input  stat_t stat,
    output cmd_t  cmd,
    output logic  busy
);

    typedef enum logic [10:0] {
        ST_IDLE       = 11'b000_0000_0001,
        ST_DRAIN      = 11'b000_0000_0010,
        ST_PREP       = 11'b000_0000_0100,
        ST_SPREAD     = 11'b000_0000_1000,
        ST_RATIO_GO   = 11'b000_0001_0000,
        ST_RATIO_WAIT = 11'b000_0010_0000,
        ST_SCALE      = 11'b000_0100_0000,
        ST_ADJ_GO     = 11'b000_1000_0000,
        ST_ADJ_WAIT   = 11'b001_0000_0000,
        ST_EMIT       = 11'b010_0000_0000,
        ST_SPARE      = 11'b100_0000_0000
    } state_t;

    state_t state_reg, state_next;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            ST_IDLE:
            begin
                cmd.accept = start;
                if (start && stat.last_item)
                begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN:
            begin
                cmd.first_target = 1'b1;
                state_next       = ST_PREP;
            end
            ST_PREP:
            begin
                cmd.prep   = 1'b1;
                state_next = ST_SPREAD;
            end
            ST_SPREAD:
            begin
                cmd.spread = 1'b1;
                state_next = ST_RATIO_GO;
            end
            ST_RATIO_GO:
            begin
                if (stat.spread_zero)
                begin
                    cmd.zero_take = 1'b1;
                    state_next    = ST_EMIT;
                end
                else
                begin
                    cmd.div_start = 1'b1;
                    state_next    = ST_RATIO_WAIT;
                end
            end
            ST_RATIO_WAIT:
            begin
                if (stat.div_done)
                begin
                    cmd.ratio_take = 1'b1;
                    state_next     = stat.diff_zero ? ST_EMIT : ST_SCALE;
                end
            end
            ST_SCALE:
            begin
                cmd.scale  = 1'b1;
                state_next = ST_ADJ_GO;
            end
            ST_ADJ_GO:
            begin
                cmd.div_start   = 1'b1;
                cmd.div_sel_adj = 1'b1;
                state_next      = ST_ADJ_WAIT;
            end
            ST_ADJ_WAIT:
            begin
                cmd.div_sel_adj = 1'b1;
                if (stat.div_done)
                begin
                    cmd.adj_take = 1'b1;
                    state_next   = ST_EMIT;
                end
            end
            ST_EMIT:
            begin
                cmd.emit   = 1'b1;
                state_next = stat.last_target ? ST_IDLE : ST_PREP;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign busy = (state_reg != ST_IDLE);

endmodule

@@ sv/regression_fit_quality.sv @@
// ----------------------------------------------------------------------------
// regression_fit_quality
// Goodness of fit (R2 and adjusted R2) of predicted against measured values.
// ----------------------------------------------------------------------------
// Usage. Items come in on a command channel: a beat of measured_value,
// predicted_value and coef_count is taken at each clock edge where start is
// high and busy is low. Beats arrive row by row, target_count beats per row,
// case_count rows per data set; coef_count is used from the first row only.
// While a data set loads, one beat is taken every cycle and busy stays low.
// The beat that completes the data set raises busy, and after a settling step
// the targets are walked one at a time: a multiply step, a spread step and a
// decision step. A zero spread goes straight to the output step. Otherwise a
// bit-serial divide forms the ratio and holds the sequencer; with the case
// count equal to the coefficient count the target then goes to the output
// step, else a scale step, a start step and a second divide come first. Each
// result is a one-cycle beat flagged by result_valid, in the cycle after its
// output step; the receiver cannot stall it. last_result marks the final
// target, and busy is low again in that same cycle.
// Configuration goes through the APB port (case_count at 0x0, target_count
// at 0x4); the user must write it only while idle, as the block itself does
// not enforce this. A write abandons a partly loaded data set.
// Reset sets case_count to 2, target_count to 1 and empties the load counters.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module regression_fit_quality
    import rfq_pkg::*;
(
    input  logic                    clk,
    input  logic                    rst_n,
    // Configuration port.
    input  logic                    psel,
    input  logic                    penable,
    input  logic                    pwrite,
    input  logic [2:0]              paddr,
    input  logic [31:0]             pwdata,
    output logic [31:0]             prdata,
    output logic                    pready,
    // Item channel.
    input  logic                    start,
    output logic                    busy,
    input  logic signed [VALUE_WIDTH-1:0] measured_value,
    input  logic signed [VALUE_WIDTH-1:0] predicted_value,
    input  logic [COEF_W-1:0]       coef_count,
    // Result channel.
    output logic                    result_valid,
    output logic [IDX_W-1:0]        target_index,
    output logic signed [OUT_W-1:0] r_squared,
    output logic signed [OUT_W-1:0] r_squared_adjusted,
    output logic [STAT_W-1:0]       status,
    output logic                    last_result
);

    logic [CASE_W-1:0] case_count_reg;
    logic [TGT_W-1:0]  target_count_reg;
    logic              cfg_write;
    logic [CASE_W-1:0] n_eff;
    logic [TGT_W-1:0]  t_eff;
    cmd_t              cmd;
    stat_t             stat;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite;

    // Registers are decoded by the word address bit alone.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            case_count_reg   <= CASE_W'(2);
            target_count_reg <= TGT_W'(1);
        end
        else if (cfg_write)
        begin
            if (paddr[2])
            begin
                target_count_reg <= pwdata[TGT_W-1:0];
            end
            else
            begin
                case_count_reg <= pwdata[CASE_W-1:0];
            end
        end
    end

    assign prdata = paddr[2] ? {{(32-TGT_W){1'b0}}, target_count_reg}
                             : {{(32-CASE_W){1'b0}}, case_count_reg};

    // A count of zero behaves as one; counts above the maximum are clamped.
    always_comb
    begin
        if (case_count_reg == '0)
        begin
            n_eff = CASE_W'(1);
        end
        else if (case_count_reg > CASE_W'(MAX_CASES))
        begin
            n_eff = CASE_W'(MAX_CASES);
        end
        else
        begin
            n_eff = case_count_reg;
        end
        if (target_count_reg == '0)
        begin
            t_eff = TGT_W'(1);
        end
        else if (target_count_reg > TGT_W'(MAX_TARGETS))
        begin
            t_eff = TGT_W'(MAX_TARGETS);
        end
        else
        begin
            t_eff = target_count_reg;
        end
    end

    rfq_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .stat  (stat),
        .cmd   (cmd),
        .busy  (busy)
    );

    rfq_datapath u_dp (
        .clk                (clk),
        .rst_n              (rst_n),
        .cmd                (cmd),
        .stat               (stat),
        .clear              (cfg_write),
        .n_eff              (n_eff),
        .t_eff              (t_eff),
        .measured_value     (measured_value),
        .predicted_value    (predicted_value),
        .coef_count         (coef_count),
        .result_valid       (result_valid),
        .target_index       (target_index),
        .r_squared          (r_squared),
        .r_squared_adjusted (r_squared_adjusted),
        .status             (status),
        .last_result        (last_result)
    );

    // Each target needs several steps, so result beats never touch.
    `ASSERT_NEXT(a_result_gap, clk, rst_n, result_valid, !result_valid)
    // The final result leaves the block ready for the next data set.
    `ASSERT_IMPLY(a_last_idle, clk, rst_n, result_valid && last_result, !busy)
    // Only an accepted beat can start the result sequence.
    `ASSERT_IMPLY(a_busy_cause, clk, rst_n, $rose(busy), $past(start))

endmodule

@@ dv/tb_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Fit quality block testbench
// Loads data sets of measured and predicted values through the item channel,
// predicts R2, adjusted R2, status and the last flag for every target, and
// checks each result beat against the oldest prediction. Register settings
// cover the clamped extremes, and a mid-set register write drops the set.
// ----------------------------------------------------------------------------
module tb_top
    import rfq_pkg::*;
();

    localparam logic [2:0] ADDR_CASES   = 3'd0;
    localparam logic [2:0] ADDR_TARGETS = 3'd4;
    localparam int         SHOW_LIMIT   = 10;

    // Data set shapes used by the random part.
    localparam int SHAPE_CLOSE_FIT = 0;
    localparam int SHAPE_WILD      = 1;
    localparam int SHAPE_FLAT      = 2;

    typedef struct packed {
        logic [IDX_W-1:0]         idx;
        logic signed [OUT_W-1:0]  r2;
        logic signed [OUT_W-1:0]  r2_adj;
        logic [STAT_W-1:0]        stat;
        logic                     last;
    } fit_result_t;

    logic clk;
    logic rst_n;
    logic psel, penable, pwrite;
    logic [2:0] paddr;
    logic [31:0] pwdata, prdata;
    logic pready;
    logic start, busy;
    logic signed [VALUE_WIDTH-1:0] measured_value, predicted_value;
    logic [COEF_W-1:0] coef_count;
    logic result_valid;
    logic [IDX_W-1:0] target_index;
    logic signed [OUT_W-1:0] r_squared, r_squared_adjusted;
    logic [STAT_W-1:0] status;
    logic last_result;

    regression_fit_quality u_dut (
        .clk(clk), .rst_n(rst_n),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready),
        .start(start), .busy(busy),
        .measured_value(measured_value), .predicted_value(predicted_value),
        .coef_count(coef_count),
        .result_valid(result_valid), .target_index(target_index),
        .r_squared(r_squared), .r_squared_adjusted(r_squared_adjusted),
        .status(status), .last_result(last_result)
    );

    // Clock: 8 ns period.
    always
    begin
        clk = 1'b1;
        #4;
        clk = 1'b0;
        #4;
    end

    // Shadow of the block: registers, stored column values and running sums.
    logic [CASE_W-1:0]             case_reg;
    logic [TGT_W-1:0]              target_reg;
    logic signed [VALUE_WIDTH-1:0] y_store [0:MAX_CASES*MAX_TARGETS-1];
    longint                        col_sum  [0:MAX_TARGETS-1];
    longint unsigned               err_sum  [0:MAX_TARGETS-1];
    logic [COEF_W-1:0]             coef_tab [0:MAX_TARGETS-1];
    int                            row_ptr, col_ptr;

    fit_result_t expected_fits[$];
    int mismatches;
    int beats_sent;
    int sets_done;
    int results_seen;
    bit quiet_sender;   // when set, the sender never idles

    function automatic int cases_eff();
        if (case_reg == 0) return 1;
        if (case_reg > MAX_CASES) return MAX_CASES;
        return case_reg;
    endfunction

    function automatic int targets_eff();
        if (target_reg == 0) return 1;
        if (target_reg > MAX_TARGETS) return MAX_TARGETS;
        return target_reg;
    endfunction

    function automatic void clear_sums();
        for (int j = 0; j < MAX_TARGETS; j++)
        begin
            col_sum[j] = 0;
            err_sum[j] = 0;
        end
        row_ptr = 0;
        col_ptr = 0;
    endfunction

    function automatic logic [OUT_W-1:0] clip32(input longint v);
        if (v > 64'sd2147483647) return 32'h7FFF_FFFF;
        if (v < -64'sd2147483648) return 32'h8000_0000;
        return v[OUT_W-1:0];
    endfunction

    // Error-to-spread ratio in Q.24, floored, capped at 2^48.
    function automatic longint unsigned spread_ratio(input longint unsigned num,
                                                     input longint unsigned den);
        longint unsigned q;
        longint unsigned rem;
        q = num / den;
        rem = num % den;
        if (q >= (64'd1 << 24)) return 64'd1 << 48;
        for (int b = 0; b < 24; b++)
        begin
            rem = rem << 1;
            q = q << 1;
            if (rem >= den)
            begin
                rem = rem - den;
                q = q | 64'd1;
            end
        end
        return q;
    endfunction

    // Folds one accepted beat into the shadow state; the beat that closes
    // the data set queues one expected result per target.
    function automatic void fold_beat(input logic signed [VALUE_WIDTH-1:0] mv,
                                      input logic signed [VALUE_WIDTH-1:0] pv,
                                      input logic [COEF_W-1:0] kc);
        int n;
        int nt;
        longint m;
        longint d;
        longint unsigned ud;
        longint unsigned sy2;
        longint unsigned sabs;
        longint unsigned dd;
        longint unsigned r;
        longint diff;
        longint t;
        longint y;
        fit_result_t res;
        n = cases_eff();
        nt = targets_eff();
        if (col_ptr >= nt || row_ptr >= n) clear_sums();
        m = mv;
        d = m - longint'(pv);
        ud = (d < 0) ? longint'(-d) : d;
        y_store[row_ptr*MAX_TARGETS + col_ptr] = mv;
        col_sum[col_ptr] += m;
        err_sum[col_ptr] += ud * ud;
        if (row_ptr == 0) coef_tab[col_ptr] = kc;
        col_ptr++;
        if (col_ptr >= nt)
        begin
            col_ptr = 0;
            row_ptr++;
        end
        if (row_ptr < n) return;

        for (int j = 0; j < nt; j++)
        begin
            sabs = (col_sum[j] < 0) ? -col_sum[j] : col_sum[j];
            sy2 = 0;
            for (int i = 0; i < n; i++)
            begin
                y = y_store[i*MAX_TARGETS + j];
                if (y < 0) y = -y;
                sy2 += y * y;
            end
            dd = longint'(n) * sy2 - sabs * sabs;
            res.idx = IDX_W'(j);
            res.r2 = '0;
            res.r2_adj = '0;
            res.stat = STATUS_OK;
            res.last = (j == nt - 1);
            if (dd == 0)
            begin
                res.stat = STATUS_ZERO_SPAN;
            end
            else
            begin
                r = spread_ratio(longint'(n) * err_sum[j], dd);
                res.r2 = clip32((64'sd1 <<< 24) - longint'(r));
                diff = longint'(n) - longint'(coef_tab[j]);
                if (diff == 0)
                begin
                    res.stat = STATUS_CASES_COEF;
                end
                else
                begin
                    t = longint'(r * longint'(n - 1)) / diff;
                    res.r2_adj = clip32((64'sd1 <<< 24) - t);
                end
            end
            expected_fits.insert(expected_fits.size(), res);
        end
        sets_done++;
        clear_sums();
    endfunction

    // Result checker: every strobed beat is matched to the oldest prediction.
    always @(posedge clk)
    begin
        fit_result_t want;
        if (rst_n && result_valid)
        begin
            results_seen++;
            if (expected_fits.size() == 0)
            begin
                mismatches++;
                if (mismatches <= SHOW_LIMIT)
                    $display("Unexpected result beat for target %0d", target_index);
            end
            else
            begin
                want = expected_fits.pop_front();
                if (want.idx !== target_index || want.r2 !== r_squared
                    || want.r2_adj !== r_squared_adjusted || want.stat !== status
                    || want.last !== last_result)
                begin
                    mismatches++;
                    if (mismatches <= SHOW_LIMIT)
                        $display({"Mismatch: exp idx %0d r2 %h adj %h st %0d last %0d,",
                                  " got idx %0d r2 %h adj %h st %0d last %0d"},
                                 want.idx, want.r2, want.r2_adj, want.stat, want.last,
                                 target_index, r_squared, r_squared_adjusted, status,
                                 last_result);
                end
            end
        end
    end

    // Register write over the APB port; only called while the block is idle.
    task automatic write_reg(input logic [2:0] addr, input logic [31:0] value);
        @(negedge clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= addr;
        pwdata <= value;
        @(negedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        if (addr == ADDR_CASES) case_reg = value[CASE_W-1:0];
        else target_reg = value[TGT_W-1:0];
        clear_sums();
        @(negedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
    endtask

    // Waits until all predicted results are in, plus a margin for a set that
    // is still between targets.
    task automatic drain();
        @(negedge clk);
        start <= 1'b0;
        wait (expected_fits.size() == 0);
        repeat (20) @(posedge clk);
    endtask

    task automatic configure(input int n, input int nt);
        drain();
        write_reg(ADDR_CASES, n);
        write_reg(ADDR_TARGETS, nt);
    endtask

    // Sends one item beat, with a random gap in front unless idling is off.
    task automatic send_item(input logic signed [VALUE_WIDTH-1:0] mv,
                             input logic signed [VALUE_WIDTH-1:0] pv,
                             input logic [COEF_W-1:0] kc);
        int gap;
        gap = (!quiet_sender && $urandom_range(99) < 28) ? $urandom_range(1, 3) : 0;
        if (gap > 0)
        begin
            @(negedge clk);
            start <= 1'b0;
            repeat (gap - 1) @(negedge clk);
        end
        @(negedge clk);
        start <= 1'b1;
        measured_value <= mv;
        predicted_value <= pv;
        coef_count <= kc;
        do @(posedge clk); while (busy);
        fold_beat(mv, pv, kc);
        beats_sent++;
    endtask

    // One full data set of the given shape at the current register setting.
    task automatic send_data_set(input int shape);
        int n;
        int nt;
        logic signed [VALUE_WIDTH-1:0] mv;
        logic signed [VALUE_WIDTH-1:0] pv;
        logic [COEF_W-1:0] kc;
        n = cases_eff();
        nt = targets_eff();
        for (int i = 0; i < n; i++)
        begin
            for (int j = 0; j < nt; j++)
            begin
                case (shape)
                    SHAPE_CLOSE_FIT:
                    begin
                        mv = 24'(int'($urandom_range(0, 1 << 20)) - (1 << 19));
                        pv = 24'(mv + int'($urandom_range(0, 1 << 14)) - (1 << 13));
                    end
                    SHAPE_FLAT:
                    begin
                        mv = 24'(j * 4099 - 70000);
                        pv = 24'($urandom);
                    end
                    default:
                    begin
                        mv = 24'($urandom);
                        pv = 24'($urandom);
                    end
                endcase
                // Coefficient counts cluster around n so the equal and the
                // larger case turn up often, with full range elsewhere.
                case ($urandom_range(3))
                    0: kc = COEF_W'(n);
                    1: kc = COEF_W'($urandom_range(0, n));
                    2: kc = COEF_W'(n + $urandom_range(1, 3));
                    default: kc = COEF_W'($urandom);
                endcase
                send_item(mv, pv, kc);
            end
        end
    endtask

    // Reset setting: two cases, one target, with extreme values.
    task automatic test_reset_setting();
        // Maximum spread with a poor fit.
        send_item(24'sh7FFFFF, 24'sh800000, 7'd1);
        send_item(24'sh800000, 24'sh7FFFFF, 7'd0);
        // Equal measured values: zero spread.
        send_item(24'sh123456, 24'sh000000, 7'd1);
        send_item(24'sh123456, 24'sh7FFFFF, 7'd0);
        // Case count equals coefficient count, perfect fit.
        send_item(-24'sd5, -24'sd5, 7'd2);
        send_item(24'sd9, 24'sd9, 7'd127);
    endtask

    // Three cases, two targets: coefficient count above the case count,
    // equal to it, and all bits of the fields set.
    task automatic test_special_cases();
        configure(3, 2);
        send_item(24'sd100, 24'sd101, 7'd127);
        send_item(24'sd0, 24'sd0, 7'd3);
        send_item(24'sd200, 24'sd199, 7'd0);
        send_item(24'sd1, 24'sd2, 7'd0);
        send_item(24'sd300, 24'sd305, 7'd0);
        send_item(-24'sd1, 24'sh7FFFFF, 7'd0);
    endtask

    // Register values out of range and a write that drops a partial set.
    task automatic test_register_clamps();
        configure(0, 31);                   // one case, sixteen targets
        send_data_set(SHAPE_WILD);
        configure(127, 0);                  // sixty-four cases, one target
        send_data_set(SHAPE_CLOSE_FIT);
        configure(4, 3);
        send_item(24'sd7, 24'sd7, 7'd4);
        send_item(24'sd8, 24'sd1, 7'd4);
        send_item(24'sd9, 24'sd3, 7'd4);
        configure(4, 3);                    // abandons the partial set
        send_data_set(SHAPE_CLOSE_FIT);
        // A long stretch of back-to-back beats with no idling.
        configure(64, 2);
        quiet_sender = 1'b1;
        send_data_set(SHAPE_WILD);
        quiet_sender = 1'b0;
    endtask

    // Random settings and shapes, mostly close fits on small sets.
    task automatic test_random_sets();
        int goal;
        int n;
        int shape;
        goal = beats_sent + 180;
        while (beats_sent < goal)
        begin
            n = ($urandom_range(9) == 0) ? $urandom_range(7, 24) : $urandom_range(1, 6);
            configure(n, $urandom_range(1, 6));
            quiet_sender = ($urandom_range(4) == 0);
            shape = $urandom_range(9);
            if (shape < 6) send_data_set(SHAPE_CLOSE_FIT);
            else if (shape < 8) send_data_set(SHAPE_WILD);
            else send_data_set(SHAPE_FLAT);
        end
        quiet_sender = 1'b0;
    endtask

    initial
    begin
        rst_n = 1'b0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        start = 1'b0;
        measured_value = '0;
        predicted_value = '0;
        coef_count = '0;
        case_reg = 2;
        target_reg = 1;
        mismatches = 0;
        beats_sent = 0;
        sets_done = 0;
        results_seen = 0;
        quiet_sender = 1'b0;
        for (int i = 0; i < MAX_TARGETS; i++) coef_tab[i] = '0;
        clear_sums();
        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_reset_setting();
        test_special_cases();
        test_register_clamps();
        test_random_sets();
        drain();
        repeat (200) @(posedge clk);

        $display("Sent %0d item beats in %0d data sets and checked %0d result beats.",
                 beats_sent, sets_done, results_seen);
        $display("Settings ran from one to sixty-four cases and one to sixteen targets.");
        if (mismatches == 0 && expected_fits.size() == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

    // Hard limit on the run length.
    initial
    begin
        #20ms;
        $display("CHECKS FAILED");
        $finish;
    end

endmodule

@@ regression_fit_quality.f @@
+incdir+sv
sv/rfq_pkg.sv
sv/rfq_divider.sv
sv/rfq_datapath.sv
sv/rfq_ctrl.sv
sv/regression_fit_quality.sv
dv/tb_top.sv
